// ===== rtl/core/boolean_netlist_evaluator_macros.svh =====
// Assertion macros shared by the netlist evaluator modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BOOLEAN_NETLIST_EVALUATOR_MACROS_SVH
`define BOOLEAN_NETLIST_EVALUATOR_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define BNE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("netlist evaluator assertion failed");

// Next-cycle implication, checked outside of reset.
`define BNE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("netlist evaluator assertion failed");

`endif

// ===== rtl/core/bne_pkg.sv =====
// Shared types and constants of the boolean netlist evaluator.
// Used by the controller, the datapath and the top level; depends on nothing.
package bne_pkg;

    // Field widths fixed by the item format.
    localparam int WIRE_W        = 12;
    localparam int LIMIT_W       = 13;
    localparam int WIRES_DEFAULT = 4096;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    // Command codes.
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_SET   = 2'd1,
        OP_GATE  = 2'd2,
        OP_READ  = 2'd3
    } bne_op_t;

    // Gate kinds.
    typedef enum logic [1:0] {
        GK_AND = 2'd0,
        GK_XOR = 2'd1,
        GK_NOT = 2'd2,
        GK_BAD = 2'd3
    } bne_kind_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_IN_RANGE      = 3'd1,
        ST_DEST_RANGE    = 3'd2,
        ST_GATE_IN_RANGE = 3'd3,
        ST_BAD_TYPE      = 3'd4,
        ST_OUT_RANGE     = 3'd5
    } bne_status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the accepted item and start the wire reads
        logic exec;   // evaluate the captured item and load the result
        logic sweep;  // write one zero entry of the clearing pass
    } bne_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_stall;   // result register full and not being taken
        logic is_clear;    // captured item is a clear command
        logic sweep_last;  // clearing pass is at its final entry
    } bne_sts_t;

endpackage

// ===== rtl/core/bne_ram.sv =====
// Generic RAM: one write port and two read ports with registered read data.
// Stand-alone; used for the wire store of the netlist evaluator.
module bne_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports; the data holds while no read is enabled.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== rtl/core/bne_ctrl.sv =====
// Controller state machine of the netlist evaluator: accept, execute, clearing pass.
// Depends on bne_pkg and the assertion macros header.
`include "boolean_netlist_evaluator_macros.svh"

module bne_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output bne_pkg::bne_ctl_t ctl,
    input  bne_pkg::bne_sts_t sts
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } bne_state_t;

    bne_state_t state_reg;
    bne_state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!sts.out_stall)
                begin
                    ctl.exec   = 1'b1;
                    state_next = sts.is_clear ? S_CLEAR : S_IDLE;
                end
            end
            S_CLEAR:
            begin
                ctl.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // State register; reset starts with a clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The result register is never overwritten while it still holds an item.
    `BNE_ASSERT_IMPL(a_exec_not_stalled, ctl.exec, !sts.out_stall)
    // An accepted item is executed before anything else.
    `BNE_ASSERT_NEXT(a_load_to_exec, ctl.load, state_reg == S_EXEC)
    // A clear command is followed by the clearing pass.
    `BNE_ASSERT_NEXT(a_clear_sweeps, ctl.exec && sts.is_clear, state_reg == S_CLEAR)

endmodule

// ===== rtl/core/bne_datapath.sv =====
// Datapath of the netlist evaluator: captured item, range checks, gate logic,
// wire store, sticky error, limit register and result register. Uses bne_pkg and bne_ram.
`include "boolean_netlist_evaluator_macros.svh"

module bne_datapath #(
    parameter int WIRES = bne_pkg::WIRES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bne_pkg::bne_ctl_t            ctl,
    output bne_pkg::bne_sts_t            sts,
    input  logic                         cfg_wr_en,
    input  logic [bne_pkg::LIMIT_W-1:0]  cfg_wr_data,
    input  logic [1:0]                   in_cmd,
    input  logic [bne_pkg::WIRE_W-1:0]   in_wire_a,
    input  logic [bne_pkg::WIRE_W-1:0]   in_wire_b,
    input  logic [bne_pkg::WIRE_W-1:0]   in_wire_dest,
    input  logic [1:0]                   in_gate_kind,
    input  logic                         in_bit_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0]                   out_status,
    output logic                         out_bit
);

    localparam int AW = (WIRES > 1) ? $clog2(WIRES) : 1;

    // Captured item.
    bne_pkg::bne_op_t             op_reg;
    bne_pkg::bne_kind_t           kind_reg;
    logic [bne_pkg::WIRE_W-1:0]   wa_reg;
    logic [bne_pkg::WIRE_W-1:0]   wb_reg;
    logic [bne_pkg::WIRE_W-1:0]   wd_reg;
    logic                         bin_reg;

    // Architectural state.
    logic [bne_pkg::LIMIT_W-1:0]  limit_reg;
    bne_pkg::bne_status_t         sticky_reg;
    bne_pkg::bne_status_t         sticky_next;
    logic [AW-1:0]                sweep_cnt_reg;
    logic [AW-1:0]                sweep_cnt_next;

    // Result register.
    logic                         valid_reg;
    logic                         valid_next;
    bne_pkg::bne_status_t         status_reg;
    logic                         bit_reg;

    // Evaluation results and store access.
    bne_pkg::bne_status_t         ev_status;
    logic                         ev_bit;
    logic                         ev_wr;
    logic [bne_pkg::WIRE_W-1:0]   ev_waddr;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic                         ram_wdata;
    logic                         rd_a;
    logic                         rd_b;

    // A wire index is valid below both the configured count and the store depth.
    function automatic logic in_range(input logic [bne_pkg::WIRE_W-1:0] idx);
        in_range = ({1'b0, idx} < limit_reg) && (32'(idx) < WIRES);
    endfunction

    // Capture the accepted item.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg   <= bne_pkg::bne_op_t'(in_cmd);
            kind_reg <= bne_pkg::bne_kind_t'(in_gate_kind);
            wa_reg   <= in_wire_a;
            wb_reg   <= in_wire_b;
            wd_reg   <= in_wire_dest;
            bin_reg  <= in_bit_in;
        end
    end

    // Evaluate the captured item against the store read data.
    always_comb
    begin
        ev_status = bne_pkg::ST_OK;
        ev_bit    = 1'b0;
        ev_wr     = 1'b0;
        ev_waddr  = wd_reg;
        if (op_reg == bne_pkg::OP_CLEAR)
        begin
            ev_status = bne_pkg::ST_OK;
        end
        else if (sticky_reg != bne_pkg::ST_OK)
        begin
            ev_status = sticky_reg;
        end
        else
        begin
            case (op_reg)
                bne_pkg::OP_SET:
                begin
                    ev_waddr = wa_reg;
                    if (in_range(wa_reg))
                    begin
                        ev_wr = 1'b1;
                    end
                    else
                    begin
                        ev_status = bne_pkg::ST_IN_RANGE;
                    end
                end
                bne_pkg::OP_GATE:
                begin
                    if (!in_range(wd_reg))
                    begin
                        ev_status = bne_pkg::ST_DEST_RANGE;
                    end
                    else if (kind_reg == bne_pkg::GK_BAD)
                    begin
                        ev_status = bne_pkg::ST_BAD_TYPE;
                    end
                    else if (!in_range(wa_reg) ||
                             (kind_reg != bne_pkg::GK_NOT && !in_range(wb_reg)))
                    begin
                        ev_status = bne_pkg::ST_GATE_IN_RANGE;
                    end
                    else
                    begin
                        ev_wr = 1'b1;
                        case (kind_reg)
                            bne_pkg::GK_AND: ev_bit = rd_a & rd_b;
                            bne_pkg::GK_XOR: ev_bit = rd_a ^ rd_b;
                            default:         ev_bit = ~rd_a;
                        endcase
                    end
                end
                default:
                begin
                    if (in_range(wa_reg))
                    begin
                        ev_bit = rd_a;
                    end
                    else
                    begin
                        ev_status = bne_pkg::ST_OUT_RANGE;
                    end
                end
            endcase
        end
    end

    // Store write: clearing pass or the evaluated write.
    always_comb
    begin
        if (ctl.sweep)
        begin
            ram_we    = 1'b1;
            ram_waddr = sweep_cnt_reg;
            ram_wdata = 1'b0;
        end
        else
        begin
            ram_we    = ctl.exec && ev_wr;
            ram_waddr = AW'(ev_waddr);
            ram_wdata = (op_reg == bne_pkg::OP_SET) ? bin_reg : ev_bit;
        end
    end

    // Wire store.
    bne_ram #(
        .WIDTH (1),
        .DEPTH (WIRES)
    ) u_wire_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ctl.load),
        .raddr_a (AW'(in_wire_a)),
        .raddr_b (AW'(in_wire_b)),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Next values of the sticky error, sweep counter and result valid.
    always_comb
    begin
        sticky_next = sticky_reg;
        if (ctl.exec)
        begin
            sticky_next = ev_status;
        end
        sweep_cnt_next = sweep_cnt_reg;
        if (ctl.sweep)
        begin
            sweep_cnt_next = sts.sweep_last ? '0 : sweep_cnt_reg + 1'b1;
        end
        if (ctl.exec)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= bne_pkg::LIMIT_RESET;
            sticky_reg    <= bne_pkg::ST_OK;
            sweep_cnt_reg <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            sticky_reg    <= sticky_next;
            sweep_cnt_reg <= sweep_cnt_next;
            valid_reg     <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            status_reg <= ev_status;
            bit_reg    <= ev_bit;
        end
    end

    // Status to the controller and result outputs.
    assign sts.out_stall  = valid_reg && !out_ready;
    assign sts.is_clear   = (op_reg == bne_pkg::OP_CLEAR);
    assign sts.sweep_last = (sweep_cnt_reg == AW'(WIRES - 1));
    assign out_valid      = valid_reg;
    assign out_status     = status_reg;
    assign out_bit        = bit_reg;

    // A pending error blocks every wire write until the next clear.
    `BNE_ASSERT_IMPL(a_sticky_blocks_write,
        ctl.exec && (sticky_reg != bne_pkg::ST_OK) && (op_reg != bne_pkg::OP_CLEAR),
        !ram_we)

endmodule

// ===== rtl/core/boolean_netlist_evaluator.sv =====
// An accepted item is captured and its wires are read into the registered read data of the store;
// it is then evaluated and loaded into the result register once that register is free or being taken.
// No new item is taken until the last one is loaded. A clear command is followed by a clearing
// pass that zeroes every wire before the next item. Reset is asynchronous and active low; after
// it a clearing pass runs before the first item is taken. The wire count register resets to 4096.
// Configuration writes are taken in every cycle.
module boolean_netlist_evaluator #(
    parameter int WIRES = bne_pkg::WIRES_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration: wire count in use.
    input  logic                        cfg_wr_en,
    input  logic [bne_pkg::LIMIT_W-1:0] cfg_wr_data,
    // Input items.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [39:0]                 s_tdata,  // wire_a[11:0], wire_b[23:12],
                                                  // wire_dest[35:24], bit_in[36], zero pad
    input  logic [3:0]                  s_tuser,  // cmd[1:0], gate_kind[3:2]
    // Result items.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,  // bit_out[0], zero pad
    output logic [2:0]                  m_tuser   // status[2:0]
);

    bne_pkg::bne_ctl_t ctl;
    bne_pkg::bne_sts_t sts;
    logic              out_bit;

    // Sequencer.
    bne_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .ctl      (ctl),
        .sts      (sts)
    );

    // Datapath with the unpacked item fields.
    bne_datapath #(
        .WIRES (WIRES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_cmd       (s_tuser[1:0]),
        .in_wire_a    (s_tdata[11:0]),
        .in_wire_b    (s_tdata[23:12]),
        .in_wire_dest (s_tdata[35:24]),
        .in_gate_kind (s_tuser[3:2]),
        .in_bit_in    (s_tdata[36]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (m_tuser),
        .out_bit      (out_bit)
    );

    // Pack the result bit into a whole byte.
    assign m_tdata = {7'b0, out_bit};

endmodule
